// ===== rtl/sparse_column_accumulator_macros.svh =====
// Assertion helpers used by the checker of the sparse column accumulator.
// Each macro puts one labeled concurrent assertion in place, clocked on the
// rising edge and held off while reset is high.
`ifndef SPARSE_COLUMN_ACCUMULATOR_MACROS_SVH
`define SPARSE_COLUMN_ACCUMULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sca_pkg.sv =====
package sca_pkg;

   localparam int VALUE_W  = 48;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 5;
   localparam int TOTAL_W  = 6;

   typedef enum logic [1:0] {
      ACT_ACCUMULATE = 2'd0,
      ACT_APPEND     = 2'd1,
      ACT_ZERO       = 2'd2,
      ACT_CLEAR      = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACC     = 3'd0,
      STATUS_APP     = 3'd1,
      STATUS_SKIP    = 3'd2,
      STATUS_FULL    = 3'd3,
      STATUS_ZEROED  = 3'd4,
      STATUS_CLEARED = 3'd5
   } status_type;

endpackage

// ===== rtl/sca_sat_add.sv =====
// Saturating adder for signed Q24.24 values.
module sca_sat_add (
   input  logic signed [sca_pkg::VALUE_W-1:0] a,
   input  logic signed [sca_pkg::VALUE_W-1:0] b,
   output logic signed [sca_pkg::VALUE_W-1:0] sum,
   output logic                               clipped
);

   logic signed [sca_pkg::VALUE_W:0] wide_sum;

   always_comb begin
      wide_sum = {a[sca_pkg::VALUE_W-1], a} + {b[sca_pkg::VALUE_W-1], b};
      // The top two bits of the wide sum differ only when the true sum
      // leaves the range; the sign bit then tells which bound to clamp to.
      clipped  = wide_sum[sca_pkg::VALUE_W] ^ wide_sum[sca_pkg::VALUE_W-1];
      if (clipped) begin
         sum = {wide_sum[sca_pkg::VALUE_W], {(sca_pkg::VALUE_W-1){~wide_sum[sca_pkg::VALUE_W]}}};
      end else begin
         sum = wide_sum[sca_pkg::VALUE_W-1:0];
      end
   end

endmodule

// ===== rtl/sparse_column_accumulator.sv =====
// Path to a result: skip and clear go straight to it, append through the append step, zero
// values sweep every entry, a hit scans to its slot and adds, a miss scans all and appends.
// Throughput: one item at a time; the next input transfer is taken in the cycle after the
// result is loaded, so the key scan through the single read port of the table sets the rate.
// Reset (synchronous, active high) empties the table and drops any pending result; the key
// and value memories are not swept, since entries are read only once written.
module sparse_column_accumulator #(
   parameter int ENTRIES  = 32,
   parameter int KEY_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input channel.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata, lowest bit up: key (KEY_BITS), value (48, signed Q24.24), zero fill.
   input  logic [((KEY_BITS+sca_pkg::VALUE_W+7)/8)*8-1:0] req_tdata,
   // tuser: action (2).
   input  logic [1:0]                             req_tuser,
   // Result channel.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata, lowest bit up: slot (5), entry_total (6), zero fill.
   output logic [15:0]                            rsp_tdata,
   // tuser, lowest bit up: status (3), saturated (1).
   output logic [3:0]                             rsp_tuser
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int VW    = sca_pkg::VALUE_W;

   // For each item the sequencer walks through those of these steps that its action needs.
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_ADD    = 6'b000100,
      S_APPEND = 6'b001000,
      S_ZERO   = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Fields of the item at work.
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic signed [VW-1:0] value_ff, value_in;

   // Table fill count and the scan and sweep pointers.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic [IDX_W-1:0] chk_ff, chk_in;
   logic             rd_vld_ff, rd_vld_in;

   // Value of the matching entry, the first operand of the saturating add.
   logic signed [VW-1:0] acc_ff, acc_in;

   // Result waiting to be handed to the output register.
   sca_pkg::status_type res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_slot_ff, res_slot_in;
   logic                res_sat_ff, res_sat_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   sca_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [sca_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [sca_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic                        rsp_sat_ff, rsp_sat_in;

   // Key and value memories: one write port, one read port with registered data.
   logic [KEY_BITS-1:0]  key_mem [ENTRIES];
   logic signed [VW-1:0] value_mem [ENTRIES];
   logic [KEY_BITS-1:0]  key_rd_ff;
   logic signed [VW-1:0] value_rd_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     wr_addr;
   logic                 wr_key_en;
   logic                 wr_value_en;
   logic signed [VW-1:0] wr_value;

   // Input fields as they stand on the port.
   sca_pkg::action_type  req_action;
   logic [KEY_BITS-1:0]  req_key;
   logic signed [VW-1:0] req_value;

   logic signed [VW-1:0] sum_value;
   logic                 sum_clipped;

   // Slot and total are reported masked to their field widths, whatever the depth.
   logic [IDX_W+sca_pkg::SLOT_W-1:0]  slot_wide;
   logic [CNT_W+sca_pkg::TOTAL_W-1:0] total_wide;

   assign req_action = sca_pkg::action_type'(req_tuser);
   assign req_key    = req_tdata[KEY_BITS-1:0];
   assign req_value  = req_tdata[KEY_BITS+VW-1:KEY_BITS];

   assign slot_wide  = {{sca_pkg::SLOT_W{1'b0}}, res_slot_ff};
   assign total_wide = {{sca_pkg::TOTAL_W{1'b0}}, count_ff};

   // New items are taken only while the sequencer is idle. A result still waiting in
   // the output register does not hold off the next transfer.
   assign req_tready = (state_ff == S_IDLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_total_ff, rsp_slot_ff};
   assign rsp_tuser  = {rsp_sat_ff, rsp_status_ff};

   // The one arithmetic unit: it folds the contribution into a matching entry.
   sca_sat_add u_sat_add (
      .a       (acc_ff),
      .b       (value_ff),
      .sum     (sum_value),
      .clipped (sum_clipped)
   );

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      iss_in        = iss_ff;
      chk_in        = chk_ff;
      rd_vld_in     = 1'b0;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_sat_in    = res_sat_ff;

      // The output register empties on its transfer and reloads below.
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_sat_in    = rsp_sat_ff;

      rd_addr       = iss_ff[IDX_W-1:0];
      wr_addr       = '0;
      wr_key_en     = 1'b0;
      wr_value_en   = 1'b0;
      wr_value      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in      = req_key;
               value_in    = req_value;
               iss_in      = '0;
               res_slot_in = '0;
               res_sat_in  = 1'b0;
               case (req_action)
                  sca_pkg::ACT_ACCUMULATE: begin
                     if (req_value == '0) begin
                        // A zero contribution leaves the table untouched.
                        res_status_in = sca_pkg::STATUS_SKIP;
                        state_in      = S_RESP;
                     end else if (count_ff == '0) begin
                        state_in = S_APPEND;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  sca_pkg::ACT_APPEND: begin
                     state_in = S_APPEND;
                  end
                  sca_pkg::ACT_ZERO: begin
                     if (count_ff == '0) begin
                        res_status_in = sca_pkg::STATUS_ZEROED;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_ZERO;
                     end
                  end
                  default: begin
                     // Emptying the table only resets the fill count.
                     count_in      = '0;
                     res_status_in = sca_pkg::STATUS_CLEARED;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Reads are issued one slot ahead of the compare, in insertion order,
            // so the first match found is the earliest entry with that key.
            if (iss_ff < count_ff) begin
               rd_vld_in = 1'b1;
               chk_in    = iss_ff[IDX_W-1:0];
               iss_in    = iss_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (key_rd_ff == key_ff) begin
                  acc_in      = value_rd_ff;
                  res_slot_in = chk_ff;
                  state_in    = S_ADD;
               end else if ((CNT_W'(chk_ff) + CNT_W'(1)) == count_ff) begin
                  // Every valid entry has been checked without a match.
                  state_in = S_APPEND;
               end
            end
         end

         S_ADD: begin
            wr_addr       = res_slot_ff;
            wr_value_en   = 1'b1;
            wr_value      = sum_value;
            res_status_in = sca_pkg::STATUS_ACC;
            res_sat_in    = sum_clipped;
            state_in      = S_RESP;
         end

         S_APPEND: begin
            if (count_ff == CNT_W'(ENTRIES)) begin
               // A full table drops the entry.
               res_status_in = sca_pkg::STATUS_FULL;
               res_slot_in   = '0;
            end else begin
               wr_addr       = count_ff[IDX_W-1:0];
               wr_key_en     = 1'b1;
               wr_value_en   = 1'b1;
               wr_value      = value_ff;
               res_status_in = sca_pkg::STATUS_APP;
               res_slot_in   = count_ff[IDX_W-1:0];
               count_in      = count_ff + CNT_W'(1);
            end
            state_in = S_RESP;
         end

         S_ZERO: begin
            // One valid entry is cleared per cycle; the keys stay.
            wr_addr     = iss_ff[IDX_W-1:0];
            wr_value_en = 1'b1;
            wr_value    = '0;
            iss_in      = iss_ff + CNT_W'(1);
            if ((iss_ff + CNT_W'(1)) == count_ff) begin
               res_status_in = sca_pkg::STATUS_ZEROED;
               state_in      = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot_wide[sca_pkg::SLOT_W-1:0];
               rsp_total_in  = total_wide[sca_pkg::TOTAL_W-1:0];
               rsp_sat_in    = res_sat_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      value_ff      <= value_in;
      iss_ff        <= iss_in;
      chk_ff        <= chk_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_sat_ff    <= res_sat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   // Table memories.
   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (wr_value_en) begin
         value_mem[wr_addr] <= wr_value;
      end
      key_rd_ff   <= key_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
   end

endmodule

// ===== rtl/sca_checker.sv =====
`include "sparse_column_accumulator_macros.svh"

module sca_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   `SCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   `SCA_ASSERT_SAME(a_sat_only_acc, clock, reset, rsp_tvalid && rsp_tuser[3], rsp_tuser[2:0] == sca_pkg::STATUS_ACC, "saturated flag on a result that added nothing")

   `SCA_ASSERT_SAME(a_slot_zero, clock, reset, rsp_tvalid && rsp_tuser[2:0] != sca_pkg::STATUS_ACC && rsp_tuser[2:0] != sca_pkg::STATUS_APP, rsp_tdata[4:0] == 5'd0, "slot reported for a result that touched no slot")

   `SCA_ASSERT_SAME(a_clear_empty, clock, reset, rsp_tvalid && rsp_tuser[2:0] == sca_pkg::STATUS_CLEARED, rsp_tdata[10:5] == 6'd0, "table not empty after a clear")

endmodule

bind sparse_column_accumulator sca_checker u_sca_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
